/* src/ptw_pkg.sv */
package ptw_pkg;

  localparam int unsigned VA_W            = 48;
  localparam int unsigned PA_W            = 48;
  localparam int unsigned DESC_W          = 64;
  localparam int unsigned IDX_W           = 9;
  localparam int unsigned OFS_W           = 12;
  localparam int unsigned LVL_W           = 2;
  localparam int unsigned WI_W            = 16;
  localparam int unsigned CFG_AW          = 5;
  localparam int unsigned REG_LSB         = 3;
  localparam int unsigned TABLE_WORDS_DEF = 65536;

  localparam logic [LVL_W-1:0] FIRST_LEVEL = 2'd0;
  localparam logic [LVL_W-1:0] LAST_LEVEL  = 2'd3;
  localparam logic [1:0]       DESC_TABLE  = 2'b11;
  localparam logic             REQ_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_WINDOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ROOT   = 2'd0,
    REG_WINDOW = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    WS_IDLE,
    WS_READ,
    WS_DONE
  } walk_state_t;

  typedef struct packed {
    logic              walk;
    logic [WI_W-1:0]   word_index;
    logic [DESC_W-1:0] data;
    logic [VA_W-1:0]   va;
  } ptw_op_t;

  typedef struct packed {
    status_t           status;
    logic [LVL_W-1:0]  level;
    logic [DESC_W-1:0] addr;
  } ptw_res_t;

  // Table index used at a given walk level
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

/* src/ptw_ram.sv */
module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/ptw_front.sv */
module ptw_front import ptw_pkg::*; #(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_req_type,
  input  logic [WI_W-1:0]   in_word_index,
  input  logic [DESC_W-1:0] in_write_data,
  input  logic [VA_W-1:0]   in_virt_addr,
  output ptw_op_t           head,
  output logic              head_valid,
  input  logic              head_pop
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ptw_op_t          q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  ptw_op_t op_in;
  logic    in_range;
  logic    enq;
  logic    deq;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  // Classify: writes beyond the table are dropped here and never queued
  always_comb begin
    in_range         = (32'(in_word_index) < TABLE_WORDS);
    op_in.walk       = (in_req_type == REQ_TRANSLATE);
    op_in.word_index = in_word_index;
    op_in.data       = in_write_data;
    op_in.va         = in_virt_addr;
    enq              = push && !full && (op_in.walk || in_range);
    deq              = head_pop && head_valid;
  end

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({enq, deq})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

/* src/ptw_back.sv */
module ptw_back import ptw_pkg::*; #(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptw_op_t           head,
  input  logic              head_valid,
  output logic              head_pop,
  input  logic [PA_W-1:0]   root_base,
  input  logic [PA_W-1:0]   window_base,
  input  logic [DESC_W-1:0] space_offset,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_status,
  output logic [LVL_W-1:0]  out_fault_level,
  output logic [DESC_W-1:0] out_addr
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);
  localparam logic [PA_W-4:0] WORDS_LIM = (PA_W-3)'(TABLE_WORDS);

  walk_state_t      state_r, state_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [VA_W-1:0]  va_r, va_nxt;
  ptw_res_t         pend_r, pend_nxt;
  ptw_res_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DESC_W-1:0] ram_rdata;

  logic [LVL_W-1:0]     lvl_sel;
  logic [VA_W-1:0]      va_sel;
  logic [PA_W-OFS_W-1:0] base_sel;
  logic [PA_W-1:0]      phys;
  logic [PA_W:0]        rel;
  logic                 in_win;
  logic                 desc_ok;
  logic [DESC_W:0]      sum;
  ptw_res_t             res;
  logic                 res_valid;
  logic                 slot_free;
  logic                 out_load;

  ptw_ram #(
    .WIDTH (DESC_W),
    .DEPTH (TABLE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Descriptor address for the level about to be read: level 0 comes from the
  // root register, deeper levels from the descriptor just read
  always_comb begin
    lvl_sel   = (state_r == WS_IDLE) ? FIRST_LEVEL : level_r + 1'b1;
    va_sel    = (state_r == WS_IDLE) ? head.va : va_r;
    base_sel  = (state_r == WS_IDLE) ? root_base[PA_W-1:OFS_W]
                                     : ram_rdata[PA_W-1:OFS_W];
    phys      = {base_sel, level_index(va_sel, lvl_sel), 3'b000};
    rel       = {1'b0, phys} - {1'b0, window_base};
    in_win    = !rel[PA_W] && (rel[PA_W-1:3] < WORDS_LIM);
    ram_raddr = rel[AW+2:3];
    ram_waddr = AW'(head.word_index);
    desc_ok   = (ram_rdata[1:0] == DESC_TABLE);
    sum       = (DESC_W+1)'({ram_rdata[PA_W-1:OFS_W], va_r[OFS_W-1:0]})
              + (DESC_W+1)'(space_offset);
    slot_free = !out_valid_r || pop;
  end

  always_comb begin
    head_pop   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_valid  = 1'b0;
    res.status = ST_OK;
    res.level  = '0;
    res.addr   = '0;
    level_nxt  = level_r;
    va_nxt     = va_r;
    case (state_r)
      WS_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          if (!head.walk) begin
            ram_we = 1'b1;
          end else begin
            va_nxt    = head.va;
            level_nxt = FIRST_LEVEL;
            if (in_win) begin
              ram_re = 1'b1;
            end else begin
              res_valid  = 1'b1;
              res.status = ST_WINDOW;
              res.level  = FIRST_LEVEL;
            end
          end
        end
      end
      WS_READ: begin
        if (!desc_ok) begin
          res_valid  = 1'b1;
          res.status = ST_INVALID;
          res.level  = level_r;
        end else if (level_r == LAST_LEVEL) begin
          res_valid = 1'b1;
          // saturate on carry out
          res.addr  = sum[DESC_W] ? '1 : sum[DESC_W-1:0];
        end else if (in_win) begin
          ram_re    = 1'b1;
          level_nxt = lvl_sel;
        end else begin
          res_valid  = 1'b1;
          res.status = ST_WINDOW;
          res.level  = lvl_sel;
        end
      end
      default: begin
      end
    endcase

    out_load      = (res_valid || (state_r == WS_DONE)) && slot_free;
    pend_nxt      = res_valid ? res : pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    if (out_load) begin
      out_nxt       = (state_r == WS_DONE) ? pend_r : res;
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    case (state_r)
      WS_IDLE, WS_READ: begin
        if (res_valid) begin
          state_nxt = slot_free ? WS_IDLE : WS_DONE;
        end else if (ram_re) begin
          state_nxt = WS_READ;
        end else begin
          state_nxt = state_r;
        end
      end
      WS_DONE:  state_nxt = slot_free ? WS_IDLE : WS_DONE;
      default:  state_nxt = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= WS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    va_r    <= va_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign empty           = !out_valid_r;
  assign out_status      = out_r.status;
  assign out_fault_level = out_r.level;
  assign out_addr        = out_r.addr;

endmodule

/* src/four_level_page_table_walker.sv */
// Four-level page table walker, 4 KiB granule, 48-bit virtual addresses.
// Table words live in a local memory of TABLE_WORDS 64-bit entries; software
// loads every word it will use (zeros included) through write words before
// translating, as unwritten entries hold no defined value. Writes to an
// index beyond the table are dropped. Items enter a two-word queue; the
// walker behind it retires a write and walks a translation by addressing
// the level 0 descriptor and then reading one descriptor per level in turn,
// as the four reads share the single read port of the table memory and each
// address depends on the previous descriptor. A walk that faults ends
// at the failing level. One finished result is held on the output while
// the next item is already walked. Registers on a 64-bit bus at byte
// addresses 0x0, 0x8, 0x10: root table base (48 bits), memory window base
// (48 bits), space offset (64 bits); write them only while the block is idle.
module four_level_page_table_walker import ptw_pkg::*; #(
  parameter int unsigned TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_req_type,
  input  logic [WI_W-1:0]   in_word_index,
  input  logic [DESC_W-1:0] in_write_data,
  input  logic [VA_W-1:0]   in_virt_addr,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_status,
  output logic [LVL_W-1:0]  out_fault_level,
  output logic [DESC_W-1:0] out_addr,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DESC_W-1:0] pwdata,
  output logic [DESC_W-1:0] prdata,
  output logic              pready
);

  logic [PA_W-1:0]   root_r, root_nxt;
  logic [PA_W-1:0]   window_r, window_nxt;
  logic [DESC_W-1:0] offset_r, offset_nxt;

  reg_idx_t reg_sel;
  logic     cfg_we;
  ptw_op_t  head;
  logic     head_valid;
  logic     head_pop;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[CFG_AW-1:REG_LSB]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    root_nxt   = root_r;
    window_nxt = window_r;
    offset_nxt = offset_r;
    if (cfg_we) begin
      case (reg_sel)
        REG_ROOT:   root_nxt   = pwdata[PA_W-1:0];
        REG_WINDOW: window_nxt = pwdata[PA_W-1:0];
        REG_OFFSET: offset_nxt = pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROOT:   prdata = DESC_W'(root_r);
      REG_WINDOW: prdata = DESC_W'(window_r);
      REG_OFFSET: prdata = offset_r;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r   <= '0;
      window_r <= '0;
      offset_r <= '0;
    end else begin
      root_r   <= root_nxt;
      window_r <= window_nxt;
      offset_r <= offset_nxt;
    end
  end

  ptw_front #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_req_type   (in_req_type),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .in_virt_addr  (in_virt_addr),
    .head          (head),
    .head_valid    (head_valid),
    .head_pop      (head_pop)
  );

  ptw_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .root_base       (root_r),
    .window_base     (window_r),
    .space_offset    (offset_r),
    .empty           (empty),
    .pop             (pop),
    .out_status      (out_status),
    .out_fault_level (out_fault_level),
    .out_addr        (out_addr)
  );

endmodule

/* src/ptw_checker.sv */
module ptw_checker import ptw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [1:0]        out_status,
  input logic [LVL_W-1:0]  out_fault_level,
  input logic [DESC_W-1:0] out_addr
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("queue full after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_addr) && $stable(out_status)
                       && $stable(out_fault_level))
    else $error("stalled result word changed");

  a_fault_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status != ST_OK |->
      (out_status == ST_INVALID || out_status == ST_WINDOW) && out_addr == '0)
    else $error("faulting walk returned an address");

  a_ok_level: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status == ST_OK |-> out_fault_level == '0)
    else $error("successful walk reports a fault level");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_status      (out_status),
  .out_fault_level (out_fault_level),
  .out_addr        (out_addr)
);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptw_pkg::*;

  localparam int unsigned WORDS        = TABLE_WORDS_DEF;
  localparam logic [63:0] PAGE_BITS    = 64'h0000_FFFF_FFFF_F000;
  localparam logic [63:0] ADDR_BITS    = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] WINDOW_BYTES = 64'(WORDS) * 64'd8;
  localparam logic [1:0]  DESC_BLOCK   = 2'b01;
  localparam logic [1:0]  DESC_RSVD    = 2'b10;
  localparam logic [1:0]  DESC_NONE    = 2'b00;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_req_type = 1'b0;
  logic [WI_W-1:0]   in_word_index = '0;
  logic [DESC_W-1:0] in_write_data = '0;
  logic [VA_W-1:0]   in_virt_addr = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        out_status;
  logic [LVL_W-1:0]  out_fault_level;
  logic [DESC_W-1:0] out_addr;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [DESC_W-1:0] pwdata = '0;
  logic [DESC_W-1:0] prdata;
  logic              pready;

  // register shadows for the walk predictor; root and window base also feed the stimulus planner
  logic [63:0] root_base = '0;
  logic [63:0] window_base = '0;
  logic [63:0] space_bias = '0;

  logic [63:0] table_copy [WORDS];
  logic [63:0] plan_words [WORDS];
  bit          plan_written [WORDS];

  ptw_op_t     pending_ops [$];
  ptw_res_t    walks_due [$];
  logic [47:0] va_pool [$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int results_seen = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int quiet_cycles = 0;

  four_level_page_table_walker #(.TABLE_WORDS(WORDS)) dut (
    .clk, .rst_n, .push, .full, .in_req_type, .in_word_index, .in_write_data,
    .in_virt_addr, .empty, .pop, .out_status, .out_fault_level, .out_addr,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  function automatic logic [8:0] va_slice(input logic [47:0] va, input int lvl);
    logic [47:0] s;
    s = va >> (39 - 9 * lvl);
    return s[8:0];
  endfunction

  // Map a descriptor address to a table word; false when outside the window.
  function automatic bit locate(input logic [63:0] phys, output logic [63:0] word);
    logic [63:0] rel;
    rel = phys - window_base;
    word = rel >> 3;
    return phys >= window_base && word < WORDS;
  endfunction

  function automatic ptw_res_t walk_tables(input logic [47:0] va);
    ptw_res_t    r;
    logic [63:0] tbl, word, desc, phys, sum;
    r.status = ST_OK;
    r.level = '0;
    r.addr = '0;
    tbl = {16'h0, root_base[47:12], 12'h000};
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (!locate(tbl + {52'h0, va_slice(va, lvl), 3'b000}, word)) begin
        r.status = ST_WINDOW;
        r.level = lvl[1:0];
        return r;
      end
      desc = table_copy[word];
      if (desc[1:0] != DESC_TABLE) begin
        r.status = ST_INVALID;
        r.level = lvl[1:0];
        return r;
      end
      tbl = {16'h0, desc[47:12], 12'h000};
    end
    phys = tbl + {52'h0, va[11:0]};
    sum = phys + space_bias;
    // clamp on carry out of 64 bits
    if (sum < phys) sum = '1;
    r.addr = sum;
    return r;
  endfunction

  function automatic logic [63:0] pick_table();
    return ((window_base + 64'd4096 * $urandom_range(126)) & PAGE_BITS) + 64'd4096;
  endfunction

  function automatic logic [63:0] make_desc(input int lvl);
    logic [63:0] d, b;
    int          pick;
    d = {$urandom, $urandom};
    b = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 4) begin
      d = '0;
    end else if (pick < 9) begin
      d[1:0] = DESC_BLOCK;
    end else if (pick < 12) begin
      d[1:0] = DESC_RSVD;
    end else if (pick < 14) begin
      d[1:0] = DESC_NONE;
    end else begin
      // tables straddling either end of the window, or anywhere at all
      if (pick < 16) b = window_base & PAGE_BITS;
      else if (pick < 18) b = (window_base + WINDOW_BYTES) & PAGE_BITS;
      else if (pick < 20 || (lvl == 3 && pick < 60)) b = {$urandom, $urandom};
      else b = pick_table();
      d[47:12] = b[47:12];
      d[1:0] = DESC_TABLE;
    end
    return d;
  endfunction

  task automatic queue_write(input logic [15:0] idx, input logic [63:0] data);
    ptw_op_t     op;
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    op.walk = !REQ_TRANSLATE;
    op.word_index = idx;
    op.data = data;
    op.va = r64[47:0];
    pending_ops.push_back(op);
    plan_words[idx] = data;
    plan_written[idx] = 1'b1;
  endtask

  // Fill every table word the walk will read before the walk itself.
  task automatic plan_translate(input logic [47:0] va);
    ptw_op_t     op;
    logic [63:0] tbl, word, r64;
    tbl = {16'h0, root_base[47:12], 12'h000};
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (!locate(tbl + {52'h0, va_slice(va, lvl), 3'b000}, word)) break;
      if (!plan_written[word]) queue_write(word[15:0], make_desc(lvl));
      if (plan_words[word][1:0] != DESC_TABLE) break;
      tbl = {16'h0, plan_words[word][47:12], 12'h000};
    end
    r64 = {$urandom, $urandom};
    op.walk = REQ_TRANSLATE;
    op.word_index = r64[15:0];
    op.data = {$urandom, $urandom};
    op.va = va;
    pending_ops.push_back(op);
  endtask

  // Hand-built tables: root at 0x0, then pages 0x1000, 0x2000, 0x3000.
  task automatic queue_directed();
    queue_write(16'd0,     {16'hFFFF, 36'h1, 10'h3FF, DESC_TABLE});
    queue_write(16'd512,   {16'h0, 36'h2, 10'h0, DESC_TABLE});
    queue_write(16'd1024,  {16'h0, 36'h3, 10'h0, DESC_TABLE});
    queue_write(16'd1536,  {16'h0, 36'hF_FFFF_FFFF, 10'h0, DESC_TABLE});
    queue_write(16'd511,   64'h0);
    queue_write(16'd513,   {16'h0, 36'h5, 10'h0, DESC_BLOCK});
    queue_write(16'd1025,  {16'h0, 36'h6, 10'h0, DESC_RSVD});
    queue_write(16'd1537,  {62'h3FFF_FFFF_FFFF_FFFF, DESC_NONE});
    queue_write(16'd1,     {16'h0, 36'hF_FFFF_FFFF, 10'h3FF, DESC_TABLE});
    queue_write(16'd514,   {16'h0, 36'h80, 10'h0, DESC_TABLE});
    queue_write(16'd1026,  {16'h0, 36'h100, 10'h0, DESC_TABLE});
    queue_write(16'd1027,  {16'h0, 36'h7F, 10'h0, DESC_TABLE});
    queue_write(16'hFFFF,  {16'h5A5A, 36'hABCDE, 10'h0, DESC_TABLE});
    queue_write(16'd3,     64'hFFFF_FFFF_FFFF_FFFF);
    plan_translate(48'h0000_0000_0FFF);
    plan_translate(48'hFFFF_FFFF_FFFF);
    plan_translate(48'h0000_4000_0000);
    plan_translate(48'h0000_0020_0000);
    plan_translate(48'h0000_0000_1000);
    plan_translate(48'h0080_0000_0000);
    plan_translate(48'h0000_8000_0000);
    plan_translate(48'h0000_0040_0000);
    plan_translate(48'h0000_007F_F123);
    plan_translate(48'h0180_0000_0000);
  endtask

  task automatic queue_random();
    logic [63:0] r64;
    logic [47:0] va;
    int          pick;
    r64 = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 15) begin
      queue_write(r64[15:0], {$urandom, $urandom});
    end else begin
      // mostly revisit known walks with fresh page offsets and, at times, last-level indices
      if (va_pool.size() != 0 && pick < 70) begin
        va = va_pool[$urandom_range(va_pool.size() - 1)];
        va[11:0] = r64[11:0];
        if (r64[63]) va[20:12] = r64[28:20];
      end else begin
        va = r64[47:0];
      end
      plan_translate(va);
      va_pool.push_back(va);
      if (va_pool.size() > 32) void'(va_pool.pop_front());
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << REG_LSB;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROOT:   root_base = value & ADDR_BITS;
      REG_WINDOW: window_base = value & ADDR_BITS;
      REG_OFFSET: space_bias = value;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pending_ops.size() != 0 || push || walks_due.size() != 0) @(negedge clk);
    // let trailing table writes retire
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [63:0] win, input logic [63:0] root,
                           input logic [63:0] bias, input int s_idle, input int r_idle,
                           input bit directed, input int count);
    settle();
    write_reg(REG_WINDOW, win);
    write_reg(REG_ROOT, root);
    write_reg(REG_OFFSET, bias);
    @(negedge clk);
    send_idle = s_idle;
    recv_idle = r_idle;
    if (directed) queue_directed();
    repeat (count) queue_random();
  endtask

  initial begin : stimulus
    logic [63:0] win3, root3;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    run_phase(64'h0, 64'hFFF, 64'h0, 33, 74, 1'b1, 340);
    run_phase(64'hFFFF_FFF8_0000, 64'hFFFF_FFFF_FFFF, '1, 74, 33, 1'b0, 300);
    win3 = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF;
    root3 = ((win3 + 64'd4096 * $urandom_range(126)) & PAGE_BITS) + 64'd4096
            + $urandom_range(4095);
    run_phase(win3, root3, {$urandom, $urandom}, 0, 0, 1'b0, 230);
    run_phase(64'hFFFF_FFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom},
              0, 0, 1'b0, 60);
    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin : feed
    ptw_op_t op;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (in_req_type == REQ_TRANSLATE) walks_due.push_back(walk_tables(in_virt_addr));
        else table_copy[in_word_index] = in_write_data;
      end
      if (!push || !full) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
          op = pending_ops.pop_front();
          push <= 1'b1;
          in_req_type <= op.walk;
          in_word_index <= op.word_index;
          in_write_data <= op.data;
          in_virt_addr <= op.va;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drain
    ptw_res_t due;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (walks_due.size() == 0) begin
          $error("unexpected word: status %0d level %0d addr %h",
                 out_status, out_fault_level, out_addr);
          errors++;
        end else begin
          due = walks_due.pop_front();
          if (out_status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_status);
            errors++;
          end
          if (out_fault_level !== due.level) begin
            $error("fault_level: expected %0d, got %0d", due.level, out_fault_level);
            errors++;
          end
          if (out_addr !== due.addr) begin
            $error("out_addr: expected %h, got %h", due.addr, out_addr);
            errors++;
          end
        end
      end
      // hold off once for a long stretch so the input side backs up
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!stall_done && results_seen >= 40) begin
        stall_left = HOLD_CYCLES;
        stall_done = 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
